>>> src/greedy_box_nms_top_defines.svh
// assertion macros for the greedy box suppression block
// used by greedy_box_nms_top; no other dependencies
`ifndef GREEDY_BOX_NMS_TOP_DEFINES_SVH
`define GREEDY_BOX_NMS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define GBNMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define GBNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define GBNMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define GBNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/gbnms_pkg.sv
// shared types and constants for the greedy box suppression block
// no dependencies
package gbnms_pkg;

	localparam int MAX_KEPT_DEF   = 128;
	localparam int COORD_BITS_DEF = 16;

	localparam int FIELD_COORD_W = 16;
	localparam int LEN_W         = 15;
	localparam int AREA_W        = 30;
	localparam int SUM_W         = 31;
	localparam int THR_W         = 16;
	localparam int PROD_W        = 47;
	localparam int IDX_W         = 16;
	localparam int CNT_OUT_W     = 8;

	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} gbnms_state_t;

	// one compare result leaving the overlap pipeline
	typedef struct packed {
		logic valid;
		logic over;
	} iou_res_t;

endpackage

>>> src/gbnms_iou.sv
// overlap test pipeline: one kept box against the current box per cycle
// depends on gbnms_pkg
module gbnms_iou #(
	parameter int EDGE_W = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [EDGE_W-1:0]          cur_left,
	input  logic signed [EDGE_W-1:0]          cur_top,
	input  logic signed [EDGE_W-1:0]          cur_right,
	input  logic signed [EDGE_W-1:0]          cur_bottom,
	input  logic signed [EDGE_W-1:0]          kept_left,
	input  logic signed [EDGE_W-1:0]          kept_top,
	input  logic signed [EDGE_W-1:0]          kept_right,
	input  logic signed [EDGE_W-1:0]          kept_bottom,
	input  logic [gbnms_pkg::AREA_W-1:0]      cur_area,
	input  logic [gbnms_pkg::AREA_W-1:0]      kept_area,
	input  logic [gbnms_pkg::THR_W-1:0]       threshold,
	output gbnms_pkg::iou_res_t               res,
	output logic                              busy
);
	import gbnms_pkg::*;

	logic                     v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [EDGE_W-1:0] lo_x_s2, hi_x_s2, lo_y_s2, hi_y_s2;
	logic [SUM_W-1:0]         sum_s2, sum_s3, sum_s4;
	logic signed [EDGE_W:0]   dx, dy;
	logic [LEN_W-1:0]         iw_s3, ih_s3;
	logic [AREA_W-1:0]        inter_s4, inter_s5, inter_s6;
	logic [SUM_W-1:0]         uni_s5;
	logic [PROD_W-1:0]        prod_s6;
	iou_res_t                 res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			res_q <= '0;
		end else begin
			v_s2        <= in_valid;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			res_q.valid <= v_s6;
			res_q.over  <= v_s6 && ({1'b0, inter_s6, 16'b0} > prod_s6);
		end
	end

	assign dx = {hi_x_s2[EDGE_W-1], hi_x_s2} - {lo_x_s2[EDGE_W-1], lo_x_s2};
	assign dy = {hi_y_s2[EDGE_W-1], hi_y_s2} - {lo_y_s2[EDGE_W-1], lo_y_s2};

	always_ff @(posedge clk) begin
		// intersection bounds
		lo_x_s2 <= (cur_left > kept_left) ? cur_left : kept_left;
		hi_x_s2 <= (cur_right < kept_right) ? cur_right : kept_right;
		lo_y_s2 <= (cur_top > kept_top) ? cur_top : kept_top;
		hi_y_s2 <= (cur_bottom < kept_bottom) ? cur_bottom : kept_bottom;
		sum_s2  <= {1'b0, cur_area} + {1'b0, kept_area};
		// overlap never exceeds the shorter side, so it fits the length width
		iw_s3   <= (!dx[EDGE_W] && dx != '0) ? dx[LEN_W-1:0] : '0;
		ih_s3   <= (!dy[EDGE_W] && dy != '0) ? dy[LEN_W-1:0] : '0;
		sum_s3  <= sum_s2;
		inter_s4 <= {{(AREA_W-LEN_W){1'b0}}, iw_s3} * {{(AREA_W-LEN_W){1'b0}}, ih_s3};
		sum_s4   <= sum_s3;
		uni_s5   <= sum_s4 - {1'b0, inter_s4};
		inter_s5 <= inter_s4;
		prod_s6  <= {{(PROD_W-THR_W){1'b0}}, threshold} * {{(PROD_W-SUM_W){1'b0}}, uni_s5};
		inter_s6 <= inter_s5;
	end

	assign res  = res_q;
	assign busy = v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | res_q.valid;

endmodule

>>> src/greedy_box_nms_top.sv
// greedy box suppression top level: kept-box store, scan sequencer, output register
// depends on gbnms_pkg, gbnms_iou and greedy_box_nms_top_defines.svh
//
//   channel    | direction | content
//   s_axis_*   | in        | one box per transfer, tuser = frame start
//   m_axis_*   | out       | one verdict per box, tuser = keep and store full
//   cfg_*      | in        | overlap threshold write, q0.16
//
// each item is scanned against the n boxes held in the store when it arrives:
// n store reads, then the pipeline drains
// a new box is taken only when the previous verdict is registered; the verdict
// waits in the output register while the next box is scanned
// reset clears counts and presets the threshold; the store itself needs no clearing pass
`include "greedy_box_nms_top_defines.svh"

module greedy_box_nms_top #(
	parameter int MAX_KEPT   = gbnms_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gbnms_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // box_left, box_top, box_width, box_height, zero pad
	input  logic        s_axis_tuser,   // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // box_index, kept_count
	output logic [1:0]  m_axis_tuser,   // keep, store_full
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import gbnms_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int EW    = ((CW > FIELD_COORD_W) ? CW : FIELD_COORD_W) + 1;
	localparam int CNTW  = $clog2(MAX_KEPT + 1);
	localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int BOXW  = 4 * EW;
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_KEPT);

	gbnms_state_t state_q, state_d;

	logic [THR_W-1:0]  thr_q;
	logic [CNTW-1:0]   total_q, rd_ptr_q;
	logic [IDX_W-1:0]  pos_q, idx_q;
	logic              drop_q;
	logic signed [EW-1:0] cur_left_q, cur_top_q, cur_right_q, cur_bottom_q;
	logic [AREA_W-1:0] cur_area_q;

	logic              in_fire, rd_en, out_load, mem_we, busy, iou_busy;
	logic              keep_now, room;
	logic [CNTW-1:0]   total_next;

	logic [BOXW-1:0]   box_mem [MAX_KEPT];
	logic [AREA_W-1:0] area_mem [MAX_KEPT];
	logic [BOXW-1:0]   box_rd_s1;
	logic [AREA_W-1:0] area_rd_s1;
	logic              rd_valid_s1;

	logic                 m_valid_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;
	logic                 out_keep_q, out_full_q;
	logic [CNTW+CNT_OUT_W-1:0] cnt_wide;

	// coordinate fields: low COORD_BITS bits, sign extended from that width
	logic [CW+FIELD_COORD_W-1:0] left_wide, top_wide;
	logic signed [CW-1:0]        left_c, top_c;
	logic signed [EW-1:0]        left_e, top_e;
	logic [LEN_W-1:0]            in_w, in_h;

	iou_res_t res;

	assign left_wide = {{CW{1'b0}}, s_axis_tdata[15:0]};
	assign top_wide  = {{CW{1'b0}}, s_axis_tdata[31:16]};
	assign left_c    = left_wide[CW-1:0];
	assign top_c     = top_wide[CW-1:0];
	assign left_e    = {{(EW-CW){left_c[CW-1]}}, left_c};
	assign top_e     = {{(EW-CW){top_c[CW-1]}}, top_c};
	assign in_w      = s_axis_tdata[46:32];
	assign in_h      = s_axis_tdata[61:47];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_ptr_q != total_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign busy       = rd_valid_s1 | iou_busy;
	assign keep_now   = !drop_q;
	assign room       = total_q < MAX_CNT;
	assign mem_we     = out_load && keep_now && room;
	assign total_next = mem_we ? total_q + 1'b1 : total_q;
	assign cnt_wide   = {{CNT_OUT_W{1'b0}}, total_next};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			total_q  <= '0;
			pos_q    <= '0;
			rd_ptr_q <= '0;
			drop_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			rd_valid_s1 <= rd_en;
			if (in_fire) begin
				// frame start empties the store and restarts numbering
				total_q  <= s_axis_tuser ? '0 : total_q;
				pos_q    <= (s_axis_tuser ? '0 : pos_q) + 1'b1;
				rd_ptr_q <= '0;
				drop_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
				if (res.valid && res.over) begin
					drop_q <= 1'b1;
				end
				total_q <= total_next;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// current box and output payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q        <= s_axis_tuser ? '0 : pos_q;
			cur_left_q   <= left_e;
			cur_top_q    <= top_e;
			cur_right_q  <= left_e + {{(EW-LEN_W){1'b0}}, in_w};
			cur_bottom_q <= top_e + {{(EW-LEN_W){1'b0}}, in_h};
			cur_area_q   <= {{(AREA_W-LEN_W){1'b0}}, in_w} * {{(AREA_W-LEN_W){1'b0}}, in_h};
		end
		if (out_load) begin
			out_idx_q  <= idx_q;
			out_cnt_q  <= cnt_wide[CNT_OUT_W-1:0];
			out_keep_q <= keep_now;
			out_full_q <= keep_now && !room;
		end
	end

	// kept-box store; the scan drains before any write, so reads never meet a write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			box_mem[total_q[AW-1:0]]  <= {cur_bottom_q, cur_right_q, cur_top_q, cur_left_q};
			area_mem[total_q[AW-1:0]] <= cur_area_q;
		end
		if (rd_en) begin
			box_rd_s1  <= box_mem[rd_ptr_q[AW-1:0]];
			area_rd_s1 <= area_mem[rd_ptr_q[AW-1:0]];
		end
	end

	gbnms_iou #(
		.EDGE_W(EW)
	) u_iou (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rd_valid_s1),
		.cur_left    (cur_left_q),
		.cur_top     (cur_top_q),
		.cur_right   (cur_right_q),
		.cur_bottom  (cur_bottom_q),
		.kept_left   (box_rd_s1[EW-1:0]),
		.kept_top    (box_rd_s1[2*EW-1:EW]),
		.kept_right  (box_rd_s1[3*EW-1:2*EW]),
		.kept_bottom (box_rd_s1[4*EW-1:3*EW]),
		.cur_area    (cur_area_q),
		.kept_area   (area_rd_s1),
		.threshold   (thr_q),
		.res         (res),
		.busy        (iou_busy)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_cnt_q, out_idx_q};
	assign m_axis_tuser  = {out_full_q, out_keep_q};

	`GBNMS_ASSERT_IMPL(a_rd_in_range, clk, arst_n, rd_en, rd_ptr_q < total_q)
	`GBNMS_ASSERT_IMPL(a_total_bound, clk, arst_n, 1'b1, total_q <= MAX_CNT)
	`GBNMS_ASSERT_IMPL(a_accept_quiet, clk, arst_n, s_axis_tready, !busy && !drop_q || !busy)
	`GBNMS_ASSERT_IMPL(a_store_kept_only, clk, arst_n, mem_we, out_load && !drop_q)
	`GBNMS_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, m_axis_tvalid)

endmodule

>>> sim/greedy_box_nms_top_tb.sv
// testbench for greedy_box_nms_top: streams detection boxes, predicts each keep/drop verdict
// in a scoreboard class and compares every verdict field; depends on gbnms_pkg and the rtl
module greedy_box_nms_top_tb;
	import gbnms_pkg::*;

	localparam longint TIMEOUT_CYCLES = 1500000;
	localparam int     MAX_KEPT       = MAX_KEPT_DEF;
	localparam int     DRAIN_CYCLES   = MAX_KEPT + 30;

	typedef struct packed {
		logic                 keep;
		logic [IDX_W-1:0]     index;
		logic [CNT_OUT_W-1:0] count;
		logic                 full;
	} verdict_t;

	typedef enum int {STYLE_SPARSE, STYLE_CLUSTER, STYLE_GRID} frame_style_t;

	class nms_scoreboard;
		logic [THR_W-1:0] thresh;
		longint           kept_left[MAX_KEPT];
		longint           kept_top[MAX_KEPT];
		longint           kept_w[MAX_KEPT];
		longint           kept_h[MAX_KEPT];
		longint unsigned  kept_area[MAX_KEPT];
		int               n_stored;
		logic [IDX_W-1:0] next_index;
		verdict_t         expected_verdicts[$];
		int               errors;
		int               n_checked;
		int               n_boxes;
		int               n_suppressed;
		int               n_overflow;

		function new();
			thresh = THR_RESET;
			n_stored = 0;
			next_index = '0;
			errors = 0;
			n_checked = 0;
			n_boxes = 0;
			n_suppressed = 0;
			n_overflow = 0;
		endfunction

		function longint unsigned span_overlap(longint a0, longint alen, longint b0, longint blen);
			longint lo;
			longint hi;
			lo = (a0 > b0) ? a0 : b0;
			hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
			return (hi > lo) ? longint'(hi - lo) : 0;
		endfunction

		// predicts the verdict of one accepted box and updates the kept-box store
		function void note_box(logic fs, logic [15:0] l, logic [15:0] t, logic [14:0] w,
				logic [14:0] h);
			longint          bl;
			longint          bt;
			longint unsigned area;
			longint unsigned inter;
			longint unsigned uni;
			bit              keep;
			verdict_t        v;
			if (fs) begin
				n_stored = 0;
				next_index = '0;
			end
			bl = longint'($signed(l));
			bt = longint'($signed(t));
			area = longint'(w) * longint'(h);
			keep = 1'b1;
			for (int j = 0; j < n_stored; j++) begin
				inter = span_overlap(bl, longint'(w), kept_left[j], kept_w[j]) *
					span_overlap(bt, longint'(h), kept_top[j], kept_h[j]);
				uni = area + kept_area[j] - inter;
				// ratio test as a product, zero union never suppresses
				if ((inter << 16) > longint'(thresh) * uni)
					keep = 1'b0;
			end
			v.keep = keep;
			v.full = 1'b0;
			if (keep) begin
				if (n_stored < MAX_KEPT) begin
					kept_left[n_stored] = bl;
					kept_top[n_stored] = bt;
					kept_w[n_stored] = longint'(w);
					kept_h[n_stored] = longint'(h);
					kept_area[n_stored] = area & 64'h3FFF_FFFF;
					n_stored++;
				end else begin
					v.full = 1'b1;
					n_overflow++;
				end
			end else begin
				n_suppressed++;
			end
			v.index = next_index;
			next_index = next_index + 1'b1;
			v.count = n_stored[CNT_OUT_W-1:0];
			expected_verdicts = {expected_verdicts, v};
			n_boxes++;
		endfunction

		function void report_field(string name, int unsigned exp_val, int unsigned act_val);
			if (exp_val != act_val) begin
				if (errors < 100)
					$display("%0t: verdict %0d field %s expected %0d actual %0d", $time,
						n_checked, name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_verdict(logic [23:0] data, logic [1:0] user);
			verdict_t v;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: verdict with no box pending, expected none actual %h/%h", $time,
					data, user);
				errors++;
				return;
			end
			v = expected_verdicts.pop_front();
			report_field("keep", v.keep, user[0]);
			report_field("store_full", v.full, user[1]);
			report_field("box_index", v.index, data[15:0]);
			report_field("kept_count", v.count, data[23:16]);
			n_checked++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	nms_scoreboard board;
	int            burst_left;
	int            n_settings;

	greedy_box_nms_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: ready pattern switches between random modes, plus long hold-offs
	initial begin
		int rx_cycle;
		int rx_mode;
		int next_hold_at;
		bit rdy;
		rx_cycle = 0;
		rx_mode = 0;
		next_hold_at = 200;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_verdict(m_axis_tdata, m_axis_tuser);
			if (board.n_checked >= next_hold_at) begin
				// sender keeps offering, so the block fills up and drops s_axis_tready
				next_hold_at += 700;
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 4) == 0);
				default: rdy = (rx_cycle % 3 != 0);
			endcase
			m_axis_tready <= rdy;
		end
	end

	// one box transfer; valid stays high while the burst lasts
	task automatic send_box(logic fs, logic [15:0] l, logic [15:0] t, logic [14:0] w,
			logic [14:0] h);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, h, w, t, l};
		s_axis_tuser <= fs;
		do @(posedge clk); while (!s_axis_tready);
		board.note_box(fs, l, t, w, h);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end
	endtask

	task automatic drain_verdicts();
		s_axis_tvalid <= 1'b0;
		while (board.expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(logic [15:0] v);
		drain_verdicts();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.thresh = v;
		n_settings++;
	endtask

	task automatic run_frame(int len, frame_style_t style);
		int          c;
		int          ncl;
		int          cx[4];
		int          cy[4];
		int          cw[4];
		int          ch[4];
		int          il;
		int          it;
		int          iw;
		int          ih;
		bit          fs;
		logic [15:0] l;
		logic [15:0] t;
		logic [14:0] w;
		logic [14:0] h;
		ncl = $urandom_range(1, 4);
		for (int k = 0; k < 4; k++) begin
			cx[k] = int'($urandom_range(0, 60000)) - 30000;
			cy[k] = int'($urandom_range(0, 60000)) - 30000;
			cw[k] = $urandom_range(64, 1024);
			ch[k] = $urandom_range(64, 1024);
		end
		l = '0;
		t = '0;
		w = '0;
		h = '0;
		for (int i = 0; i < len; i++) begin
			fs = (i == 0) || (style != STYLE_GRID && $urandom_range(0, 50) == 0);
			case (style)
				STYLE_SPARSE: begin
					l = 16'($urandom);
					t = 16'($urandom);
					w = 15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) :
						$urandom_range(0, 4096));
					h = 15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) :
						$urandom_range(0, 4096));
				end
				STYLE_CLUSTER: begin
					c = $urandom_range(0, ncl - 1);
					il = cx[c] + int'($urandom_range(0, cw[c] / 4)) - cw[c] / 8;
					it = cy[c] + int'($urandom_range(0, ch[c] / 4)) - ch[c] / 8;
					iw = cw[c] + int'($urandom_range(0, cw[c] / 4)) - cw[c] / 8;
					ih = ch[c] + int'($urandom_range(0, ch[c] / 4)) - ch[c] / 8;
					l = il[15:0];
					t = it[15:0];
					w = ($urandom_range(0, 30) == 0) ? 15'd0 : iw[14:0];
					h = ih[14:0];
				end
				default: begin
					// disjoint cells fill the store; every twelfth box repeats the last one
					if (i % 12 != 11) begin
						il = -32768 + (i % 16) * 4096 + int'($urandom_range(0, 40));
						it = -32768 + (i / 16) * 4096 + int'($urandom_range(0, 40));
						l = il[15:0];
						t = it[15:0];
						w = 15'($urandom_range(1, 4000));
						h = 15'($urandom_range(1, 4000));
					end
				end
			endcase
			send_box(fs, l, t, w, h);
		end
	endtask

	initial begin
		logic [15:0] thr;
		int          n_items;
		int          len;
		board = new();
		n_settings = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed boxes at the reset threshold
		send_box(1, 0, 0, 16, 16);
		send_box(0, 0, 0, 16, 16);                  // identical box
		send_box(0, 8, 0, 16, 16);                  // one third overlap, kept
		send_box(0, 16, 0, 16, 16);                 // shares an edge only with the first
		send_box(0, 4, 0, 16, 16);                  // large overlap, suppressed
		send_box(0, 100, 100, 0, 0);                // zero area
		send_box(0, 100, 100, 0, 0);                // zero union against the last one
		send_box(0, 100, 100, 0, 16);
		send_box(0, -32768, -32768, 32767, 32767);
		send_box(0, 32767, 32767, 32767, 32767);
		send_box(0, -1, -1, 1, 1);                  // just outside the big box
		send_box(0, -16384, -16384, 16384, 16384);  // mostly inside the big box, one unit past its right and bottom edges
		send_box(0, -32768, -32768, 32767, 32766);
		send_box(1, 5, 5, 10, 10);
		send_box(0, 5, 5, 10, 10);
		send_box(1, 0, 0, 0, 0);
		send_box(1, 32767, -32768, 0, 32767);
		send_box(0, -32768, 32767, 32767, 0);
		send_box(0, 16'h5555, 16'hAAAA, 15'h2AAA, 15'h5555);
		send_box(0, 16'hAAAA, 16'h5555, 15'h5555, 15'h2AAA);
		send_box(0, 16'h5560, 16'hAAB0, 15'h2AAA, 15'h5555);

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: thr = 16'h0000;
				1: thr = 16'hFFFF;
				2: thr = 16'h0001;
				3: thr = 16'h8000;
				4: thr = THR_RESET;
				default: thr = 16'($urandom);
			endcase
			set_threshold(thr);
			n_items = 0;
			if (p == 2 || p == 5 || p == 7) begin
				run_frame(150, STYLE_GRID);
				n_items += 150;
			end
			while (n_items < 150) begin
				len = $urandom_range(1, 30);
				run_frame(len, ($urandom_range(0, 2) == 0) ? STYLE_SPARSE : STYLE_CLUSTER);
				n_items += len;
			end
		end

		drain_verdicts();
		$display("covered %0d boxes under %0d threshold writes plus the reset value",
			board.n_boxes, n_settings);
		$display("verdicts: %0d suppressed, %0d kept with the store already full",
			board.n_suppressed, board.n_overflow);
		if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/gbnms_pkg.sv
src/gbnms_iou.sv
src/greedy_box_nms_top.sv
sim/greedy_box_nms_top_tb.sv
